// File: hdl/nse_pkg.sv
// Shared types, register indexes and calendar helpers for the schedule expiry unit.
// No dependencies; every module of the block imports this package.
package nse_pkg;

	// configuration port geometry
	localparam int APB_AW = 5;
	localparam int APB_DW = 32;

	// register indexes (byte address / 4)
	localparam logic [2:0] REG_MINUTE  = 3'd0;
	localparam logic [2:0] REG_HOUR    = 3'd1;
	localparam logic [2:0] REG_DAY     = 3'd2;
	localparam logic [2:0] REG_MONTH   = 3'd3;
	localparam logic [2:0] REG_WEEKDAY = 3'd4;

	// calendar constants
	localparam logic [5:0] MINUTE_MAX  = 6'd59;
	localparam logic [4:0] HOUR_MAX    = 5'd23;
	localparam logic [4:0] DAY_MAX     = 5'd30;
	localparam logic [3:0] MONTH_MAX   = 4'd11;
	localparam logic [2:0] WEEKDAY_BAD = 3'd7;
	localparam logic [3:0] WEEK_LEN    = 4'd7;
	localparam logic [5:0] WEEK_DAYS   = 6'd7;

	localparam logic [4:0] MONTH_DAYS [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	// decoded schedule; *_fix low means "any"
	typedef struct packed {
		logic       min_fix;
		logic [5:0] min;
		logic       hour_fix;
		logic [4:0] hour;
		logic       day_fix;
		logic [4:0] day;
		logic       mon_fix;
		logic [3:0] mon;
		logic       wday_fix;
		logic [2:0] wday;
	} sched_t;

	// one query beat
	typedef struct packed {
		logic [9:0] year;
		logic [3:0] month;
		logic [4:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [2:0] weekday;
	} query_t;

	// one result beat
	typedef struct packed {
		logic        spec_error;
		logic [10:0] year;
		logic [3:0]  month;
		logic [5:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
	} result_t;

	// Gregorian leap test on years counted from 1900 (up to 2924)
	function automatic logic is_leap(input logic [10:0] y);
		logic plain_century;
		plain_century = y inside {11'd0, 11'd200, 11'd300, 11'd400,
			11'd600, 11'd700, 11'd800, 11'd1000};
		return (y[1:0] == 2'b00) && !plain_century;
	endfunction

	// days in a zero-based month (month already within range)
	function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
		logic [4:0] len;
		len = MONTH_DAYS[mon];
		if (mon == 4'd1 && leap) begin
			len = 5'd29;
		end
		return len;
	endfunction

endpackage

// File: hdl/nse_cfg.sv
// APB-style register file holding the five schedule registers.
// Depends on nse_pkg; presents the decoded schedule to the calendar core.
module nse_cfg import nse_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output sched_t            sched
);

	logic [6:0] minute_q;
	logic [5:0] hour_q;
	logic [5:0] day_q;
	logic [4:0] month_q;
	logic [3:0] weekday_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];

	// write on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			minute_q  <= '1;
			hour_q    <= '1;
			day_q     <= '1;
			month_q   <= '1;
			weekday_q <= '1;
		end else if (wr_en) begin
			case (reg_idx)
				REG_MINUTE:  minute_q  <= pwdata[6:0];
				REG_HOUR:    hour_q    <= pwdata[5:0];
				REG_DAY:     day_q     <= pwdata[5:0];
				REG_MONTH:   month_q   <= pwdata[4:0];
				REG_WEEKDAY: weekday_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	// read back raw register bits
	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_MINUTE:  prdata = {25'd0, minute_q};
			REG_HOUR:    prdata = {26'd0, hour_q};
			REG_DAY:     prdata = {26'd0, day_q};
			REG_MONTH:   prdata = {27'd0, month_q};
			REG_WEEKDAY: prdata = {28'd0, weekday_q};
			default:     prdata = '0;
		endcase
	end

	// decode: top bit means any, saturate values above range, weekday 7 reads as 0
	always_comb begin
		sched.min_fix  = !minute_q[6];
		sched.min      = (minute_q[5:0] > MINUTE_MAX) ? MINUTE_MAX : minute_q[5:0];
		sched.hour_fix = !hour_q[5];
		sched.hour     = (hour_q[4:0] > HOUR_MAX) ? HOUR_MAX : hour_q[4:0];
		sched.day_fix  = !day_q[5];
		sched.day      = (day_q[4:0] > DAY_MAX) ? DAY_MAX : day_q[4:0];
		sched.mon_fix  = !month_q[4];
		sched.mon      = (month_q[3:0] > MONTH_MAX) ? MONTH_MAX : month_q[3:0];
		sched.wday_fix = !weekday_q[3];
		sched.wday     = (weekday_q[2:0] == WEEKDAY_BAD) ? 3'd0 : weekday_q[2:0];
	end

endmodule

// File: hdl/nse_calc.sv
// Calendar core: next expiry time of the schedule for one registered query.
// Depends on nse_pkg; purely combinational, sits between the two pipeline registers.
module nse_calc import nse_pkg::*; (
	input  sched_t  sched,
	input  query_t  query,
	output result_t res
);

	// normalized current time
	logic [3:0]  t_mon;
	logic [4:0]  t_len;
	logic [4:0]  t_last;
	logic [4:0]  t_cd;
	logic [4:0]  t_day;
	logic [4:0]  t_hour;
	logic [5:0]  t_min;
	logic [2:0]  t_wd;

	// field comparisons
	logic        weekly;
	logic [4:0]  md;
	logic        p_mon, p_day, p_hour, p_min;
	logic        lt_mon, lt_day, lt_hour, lt_min;
	logic        reach_day, reach_hour, reach_min, reach_end;
	logic [3:0]  wsum;
	logic [2:0]  wdays;
	logic        wzero;

	// roll entry points
	logic        st_year, st_mon, st_day, st_hour, st_min;

	// base values and roll chain
	logic [5:0]  min_b, min_n;
	logic [4:0]  hour_b, hour_n;
	logic [4:0]  day_b, day_n, day_f;
	logic [3:0]  mon_b, mon_n;
	logic [10:0] year_n;
	logic [4:0]  f_len;
	logic        cin_h, cin_d, cin_m;
	logic        cout_min, cout_h, cout_d, cout_m;
	logic [5:0]  wk_day;

	always_comb begin
		// saturate and clamp the query fields
		t_mon  = (query.month > MONTH_MAX) ? MONTH_MAX : query.month;
		t_len  = month_len(t_mon, is_leap({1'b0, query.year}));
		t_last = t_len - 5'd1;
		t_cd   = (query.day == 5'd0) ? 5'd1 : query.day;
		if (t_cd > t_len) begin
			t_cd = t_len;
		end
		t_day  = t_cd - 5'd1;
		t_hour = (query.hour > HOUR_MAX) ? HOUR_MAX : query.hour;
		t_min  = (query.minute > MINUTE_MAX) ? MINUTE_MAX : query.minute;
		t_wd   = (query.weekday == WEEKDAY_BAD) ? 3'd0 : query.weekday;

		weekly = sched.wday_fix;

		// days until the scheduled weekday
		wsum  = {1'b0, sched.wday} + WEEK_LEN - {1'b0, t_wd};
		wdays = (wsum >= WEEK_LEN) ? 3'(wsum - WEEK_LEN) : wsum[2:0];
		wzero = (wdays == 3'd0);

		// walk from month down to minute
		md      = (sched.day < t_last) ? sched.day : t_last;
		p_mon   = !sched.mon_fix || (sched.mon == t_mon);
		lt_mon  = sched.mon < t_mon;
		p_day   = !sched.day_fix || (md == t_day);
		lt_day  = md < t_day;
		p_hour  = !sched.hour_fix || (sched.hour == t_hour);
		lt_hour = sched.hour < t_hour;
		p_min   = !sched.min_fix || (sched.min == t_min);
		lt_min  = sched.min < t_min;

		reach_day  = p_mon;
		reach_hour = weekly ? wzero : (p_mon && p_day);
		reach_min  = reach_hour && p_hour;
		reach_end  = reach_min && p_min;

		st_year = !weekly && !p_mon && lt_mon;
		st_mon  = !weekly && reach_day && !p_day && lt_day;
		st_day  = reach_hour && !p_hour && lt_hour;
		st_hour = reach_min && !p_min && lt_min;
		st_min  = reach_end;

		// fixed fields, else current value once reached, else zero
		min_b  = sched.min_fix ? sched.min : (reach_min ? t_min : 6'd0);
		hour_b = sched.hour_fix ? sched.hour : (reach_hour ? t_hour : 5'd0);
		day_b  = sched.day_fix ? sched.day : (reach_day ? t_day : 5'd0);
		mon_b  = sched.mon_fix ? sched.mon : t_mon;

		// minute roll
		min_n = min_b;
		if (st_min && !sched.min_fix) begin
			min_n = (min_b == MINUTE_MAX) ? 6'd0 : min_b + 6'd1;
		end
		cout_min = st_min && (sched.min_fix || (min_b == MINUTE_MAX));

		// hour roll
		cin_h  = cout_min || st_hour;
		hour_n = hour_b;
		if (cin_h && !sched.hour_fix) begin
			hour_n = (hour_b == HOUR_MAX) ? 5'd0 : hour_b + 5'd1;
		end
		cout_h = cin_h && (sched.hour_fix || (hour_b == HOUR_MAX));

		// day roll: monthly wraps at month length, weekly adds a week
		cin_d = cout_h || st_day;
		day_n = day_b;
		if (cin_d && !sched.day_fix) begin
			day_n = (day_b == t_last) ? 5'd0 : day_b + 5'd1;
		end
		cout_d = cin_d && (sched.day_fix || (day_b == t_last));
		wk_day = {1'b0, t_day} + {3'd0, wdays} + (cin_d ? WEEK_DAYS : 6'd0);

		// month and year roll
		cin_m = cout_d || st_mon;
		mon_n = mon_b;
		if (cin_m && !sched.mon_fix) begin
			mon_n = (mon_b == MONTH_MAX) ? 4'd0 : mon_b + 4'd1;
		end
		cout_m = cin_m && (sched.mon_fix || (mon_b == MONTH_MAX));
		year_n = {1'b0, query.year} + {10'd0, (cout_m || st_year)};

		// clamp monthly day to the length of the final month
		f_len = month_len(mon_n, is_leap(year_n));
		day_f = (day_n > f_len - 5'd1) ? f_len - 5'd1 : day_n;

		// assemble the result beat
		if (sched.wday_fix && (sched.day_fix || sched.mon_fix)) begin
			res = '0;
			res.spec_error = 1'b1;
		end else if (weekly) begin
			res.spec_error = 1'b0;
			res.year       = {1'b0, query.year};
			res.month      = t_mon;
			res.day        = wk_day + 6'd1;
			res.hour       = hour_n;
			res.minute     = min_n;
		end else begin
			res.spec_error = 1'b0;
			res.year       = year_n;
			res.month      = mon_n;
			res.day        = {1'b0, day_f} + 6'd1;
			res.hour       = hour_n;
			res.minute     = min_n;
		end
	end

endmodule

// File: hdl/next_schedule_expiry_unit.sv
// Top level of the schedule expiry unit: query register, calendar core, result register.
// Depends on nse_pkg, nse_cfg and nse_calc.
//
//  channel | handshake                    | payload
//  --------+------------------------------+-------------------------------------------
//  query   | query_valid / query_stall    | cur_year .. cur_weekday (cur_second unused)
//  result  | result_valid / result_stall  | spec_error, next_year .. next_minute
//  config  | psel/penable/pwrite, pready  | paddr, pwdata, prdata
//
// One query per cycle while the result is not stalled; a query passes the query register,
// then the result register, the calendar walk in one pass of logic between them.
// Reset clears both valid flags and sets every schedule register to "any".
// A stalled result holds in the result register; the query register still fills
// behind it, and query_stall rises only when both stages hold a beat.
// Seconds never affect the result: the expiry always has zero seconds.
module next_schedule_expiry_unit import nse_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	input  logic              query_valid,
	output logic              query_stall,
	input  logic [9:0]        cur_year,
	input  logic [3:0]        cur_month,
	input  logic [4:0]        cur_day,
	input  logic [4:0]        cur_hour,
	input  logic [5:0]        cur_minute,
	input  logic [5:0]        cur_second,
	input  logic [2:0]        cur_weekday,
	output logic              result_valid,
	input  logic              result_stall,
	output logic              spec_error,
	output logic [10:0]       next_year,
	output logic [3:0]        next_month,
	output logic [5:0]        next_day,
	output logic [4:0]        next_hour,
	output logic [5:0]        next_minute
);

	sched_t  sched;
	query_t  query_s1;
	logic    valid_s1;
	result_t res_comb;
	result_t res_s2;
	logic    valid_s2;
	logic    adv_s2;
	logic    adv_s1;

	nse_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.sched   (sched)
	);

	// stage moves when its downstream slot is free
	assign adv_s2      = !valid_s2 || !result_stall;
	assign adv_s1      = !valid_s1 || adv_s2;
	assign query_stall = !adv_s1;

	// hold the query beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= query_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && query_valid) begin
			query_s1.year    <= cur_year;
			query_s1.month   <= cur_month;
			query_s1.day     <= cur_day;
			query_s1.hour    <= cur_hour;
			query_s1.minute  <= cur_minute;
			query_s1.weekday <= cur_weekday;
		end
	end

	nse_calc u_calc (
		.sched (sched),
		.query (query_s1),
		.res   (res_comb)
	);

	// hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign result_valid = valid_s2;
	assign spec_error   = res_s2.spec_error;
	assign next_year    = res_s2.year;
	assign next_month   = res_s2.month;
	assign next_day     = res_s2.day;
	assign next_hour    = res_s2.hour;
	assign next_minute  = res_s2.minute;

endmodule
